@@ rtl/core/mlp_compensation_6_10_6_defines.svh @@
`ifndef MLP_COMPENSATION_6_10_6_DEFINES_SVH
`define MLP_COMPENSATION_6_10_6_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MLPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define MLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mlpc_pkg.sv @@
package mlpc_pkg;

    // Network shape.
    localparam int INPUT_COUNT  = 6;
    localparam int HIDDEN_COUNT = 10;
    localparam int OUTPUT_COUNT = 6;

    // Datapath widths.
    localparam int SAMPLE_W = 16;
    localparam int XN_W     = 18;
    localparam int HSUM_W   = 20;
    localparam int ACT_W    = 14;
    localparam int MUL_W    = 22;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 58;
    localparam int EST_W    = 27;

    // Fixed-point shifts.
    localparam int NRM_SHIFT = 12;
    localparam int HID_SHIFT = 16;
    localparam int OUT_SPLIT = 18;
    localparam int OHI_W     = 18;
    localparam int OUT_SHIFT = 32;

    // Tanh table geometry.
    localparam int TANH_TABLE_DEPTH = 256;
    localparam int TANH_SPAN_Q12    = 16384;
    localparam int TANH_STEP        = TANH_SPAN_Q12 / TANH_TABLE_DEPTH;
    localparam int TANH_STEP_SH     = $clog2(TANH_STEP);
    localparam int TANH_IDX_W       = $clog2(TANH_TABLE_DEPTH);
    localparam int TANH_ROM_N       = TANH_TABLE_DEPTH + 1;
    localparam int ROM_AW           = $clog2(TANH_ROM_N);
    localparam int TANH_W           = 13;
    localparam int TANH_ONE         = 4096;

    // Rounding and offset constants.
    localparam longint NRM_BASE_OFF = (longint'(1) <<< (NRM_SHIFT - 1))
                                    - (longint'(1) <<< (2 * NRM_SHIFT));
    localparam longint HID_ROUND    = longint'(1) <<< (HID_SHIFT - 1);
    localparam longint Q24_ONE      = longint'(1) <<< (2 * NRM_SHIFT);
    localparam longint OUT_ROUND    = longint'(1) <<< (OUT_SHIFT - 1);
    localparam longint TANH_HALF    = longint'(TANH_STEP / 2);
    localparam longint EST_MAX      = 32767;
    localparam longint EST_MIN      = -32768;
    localparam longint unsigned ONE_Q31 = 64'h8000_0000;

    typedef longint t_in_tab  [INPUT_COUNT];
    typedef longint t_hid_tab [HIDDEN_COUNT];
    typedef longint t_out_tab [OUTPUT_COUNT];
    typedef longint t_hid_w   [HIDDEN_COUNT][INPUT_COUNT];
    typedef longint t_out_w   [OUTPUT_COUNT][HIDDEN_COUNT];
    typedef logic [TANH_W-1:0] t_tanh_rom [TANH_ROM_N];

    // Input normalization: offset in Q.8, gain in Q.16.
    localparam t_in_tab IN_OFF_Q8   = '{8669, 7951, 8257, 7693, 8362, 8659};
    localparam t_in_tab IN_GAIN_Q16 = '{4161, 3742, 3917, 3614, 4020, 4043};

    // Hidden layer, Q.16.
    localparam t_hid_tab HID_BIAS_Q16 = '{
        57099, 49275, 44446, -43748, 47855, -50548, 47771, -48258, 47267, 47991};
    localparam t_hid_w HID_W_Q16 = '{
        '{-34111, 10521, -6875, -8262, 6315, 11937},
        '{-145, 3568, -1674, -17789, 10470, -7343},
        '{-639, -7392, 2484, -2464, -10825, 5917},
        '{-651, 6906, 965, -368, 5535, -521},
        '{7939, -8844, 3533, 1282, -6010, -14874},
        '{-1871, -5329, 5670, 10330, -4560, 7055},
        '{14125, 3727, -8966, -1305, 4609, -32696},
        '{-4177, -6978, 9637, 3663, -841, 12806},
        '{2905, -5849, 2418, 851, -13502, -3484},
        '{2911, -9938, -3596, 3721, -4118, -1063}};

    // Output layer, Q.12.
    localparam t_out_tab OUT_BIAS_Q12 = '{21242, -18171, 37180, 46295, 125055, -6618};
    localparam t_out_w OUT_W_Q12 = '{
        '{3898, 49937, -84989, -176502, -17055, 148011, 5057, -82895, -18669, -74081},
        '{-8376, -42975, -23904, 66495, -34291, -83307, 15412, 50518, 28056, 122427},
        '{5906, 64927, 187409, 493941, 34573, 155795, -17938, -110697, -28113, 215494},
        '{-2652, 134378, 604066, 766763, 467918, 690907, -237824, -814931, -508292,
          111586},
        '{-25930, 464625, -105378, -294766, -92039, 1048611, -51902, -460351, 54496,
          -105765},
        '{-17223, 101401, 217857, 245292, 208362, 139008, -45808, -102053, -234102,
          61485}};

    // Reverse normalization: reciprocal gain in Q.16, offset in Q.8.
    localparam t_out_tab OUT_RGAIN_Q16 = '{655275, 655216, 882332, 524235, 524227, 524167};
    localparam t_out_tab OUT_OFF_Q8    = '{-2559, -2560, 8979, -2048, -2048, -2048};

    // Normalization accumulator start: rounding, the minus-one shift and the offset term.
    function automatic t_in_tab build_nrm_base();
        t_in_tab tab;
        for (int c = 0; c < INPUT_COUNT; c++) begin
            tab[c] = NRM_BASE_OFF - IN_OFF_Q8[c] * IN_GAIN_Q16[c];
        end
        return tab;
    endfunction

    // Hidden accumulator start: bias moved to Q.28 plus rounding.
    function automatic t_hid_tab build_hid_init();
        t_hid_tab tab;
        for (int h = 0; h < HIDDEN_COUNT; h++) begin
            tab[h] = (HID_BIAS_Q16[h] <<< NRM_SHIFT) + HID_ROUND;
        end
        return tab;
    endfunction

    // Output accumulator start: bias moved to Q.24 plus the constant one.
    function automatic t_out_tab build_out_init();
        t_out_tab tab;
        for (int o = 0; o < OUTPUT_COUNT; o++) begin
            tab[o] = (OUT_BIAS_Q12[o] <<< NRM_SHIFT) + Q24_ONE;
        end
        return tab;
    endfunction

    // Unsigned long division by shift and subtract, used only to build the table.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Tanh table in Q.12: exp from a Taylor series in Q.31, squared four times.
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom rom;
        longint unsigned r;
        longint unsigned term;
        longint unsigned e;
        longint acc;
        for (int k = 0; k < TANH_ROM_N; k++) begin
            r = 64'(2 * k * TANH_STEP);
            r = r << 15;
            if (r > (ONE_Q31 >> 1)) begin
                r = ONE_Q31 >> 1;
            end
            term = ONE_Q31;
            acc  = longint'(ONE_Q31);
            for (int t = 1; t <= 16; t++) begin
                term = div_u64((term * r) >> 31, 64'(t));
                if (t[0]) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(ONE_Q31)) begin
                acc = longint'(ONE_Q31);
            end
            e = acc;
            for (int q = 0; q < 4; q++) begin
                e = (e * e + (ONE_Q31 >> 1)) >> 31;
            end
            rom[k] = TANH_W'(div_u64(2 * (ONE_Q31 - e) * TANH_ONE + (ONE_Q31 + e),
                                     2 * (ONE_Q31 + e)));
        end
        return rom;
    endfunction

    localparam t_in_tab   NRM_BASE = build_nrm_base();
    localparam t_hid_tab  HID_INIT = build_hid_init();
    localparam t_out_tab  OUT_INIT = build_out_init();
    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_5;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] estimate_0;
        logic signed [SAMPLE_W-1:0] estimate_1;
        logic signed [SAMPLE_W-1:0] estimate_2;
        logic signed [SAMPLE_W-1:0] estimate_3;
        logic signed [SAMPLE_W-1:0] estimate_4;
        logic signed [SAMPLE_W-1:0] estimate_5;
    } t_out_word;

endpackage

@@ rtl/core/mlp_compensation_6_10_6.sv @@
// Sensor compensation network: six Q7.8 samples in, six Q7.8 estimates out.
// Input channel: i_valid / o_stall with the sample word on i_data. A word is
// taken on a rising edge with i_valid high and o_stall low. o_stall is high
// for the whole time the block works on a word.
// Output channel: o_valid / i_stall with the estimate word on o_data, held in
// an output register until it is taken.
// One shared multiplier does all the multiplications under a sequencer:
// 6 normalization steps, then for each of 10 hidden neurons 6 products and
// 4 tanh steps (table read, interpolation), then for each of 6 outputs 10
// products and 3 steps of reverse scaling and saturation.
// No new word is taken until the last result has been handed to the output register.
// The next word is taken while an earlier result still waits in the output
// register; if the receiver stalls, the block holds its new result until
// the register is free.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid. No state is kept between words.

`include "mlp_compensation_6_10_6_defines.svh"

module mlp_compensation_6_10_6
    import mlpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    localparam int IN_IW  = $clog2(INPUT_COUNT);
    localparam int HID_IW = $clog2(HIDDEN_COUNT);
    localparam int OUT_IW = $clog2(OUTPUT_COUNT);

    localparam logic [IN_IW-1:0]  LAST_IN  = IN_IW'(INPUT_COUNT - 1);
    localparam logic [HID_IW-1:0] LAST_HID = HID_IW'(HIDDEN_COUNT - 1);
    localparam logic [OUT_IW-1:0] LAST_OUT = OUT_IW'(OUTPUT_COUNT - 1);
    localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(TANH_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NRM,
        S_HID_MAC,
        S_TNH_A,
        S_TNH_B,
        S_TNH_C,
        S_TNH_D,
        S_OUT_MAC,
        S_OUT_HI,
        S_OUT_LO,
        S_OUT_RND,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [IN_IW-1:0]           r_i, n_i;
    logic [HID_IW-1:0]          r_h, n_h;
    logic [OUT_IW-1:0]          r_o, n_o;
    logic signed [SAMPLE_W-1:0] r_samp [INPUT_COUNT];
    logic signed [SAMPLE_W-1:0] n_samp [INPUT_COUNT];
    logic signed [XN_W-1:0]     r_xn [INPUT_COUNT];
    logic signed [XN_W-1:0]     n_xn [INPUT_COUNT];
    logic signed [ACT_W-1:0]    r_act [HIDDEN_COUNT];
    logic signed [ACT_W-1:0]    n_act [HIDDEN_COUNT];
    logic signed [SAMPLE_W-1:0] r_est [OUTPUT_COUNT];
    logic signed [SAMPLE_W-1:0] n_est [OUTPUT_COUNT];
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [TANH_W-1:0]          r_t0, n_t0;
    logic [TANH_W-1:0]          r_rom_q;
    logic [TANH_STEP_SH-1:0]    r_frac, n_frac;
    logic                       r_neg, n_neg;
    logic [ROM_AW-1:0]          r_addr, n_addr, rom_addr;
    logic [OUT_SPLIT-1:0]       r_lo, n_lo;
    logic                       r_out_valid, n_out_valid;
    t_out_word                  r_out, n_out;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    nrm_sum, rnd_sum;
    logic signed [HSUM_W-1:0]   hid_sum;
    logic [HSUM_W-1:0]          hid_mag;
    logic                       hid_sat;
    logic signed [TANH_W:0]     tnh_diff;
    logic signed [ACT_W-1:0]    tnh_val;
    logic signed [EST_W-1:0]    est_full;

    // Shared multiplier; its operands are chosen by the sequencer.
    assign mul_p = mul_a * mul_b;

    // Normalized sample: start value plus sample times gain, scaled to Q.12.
    assign nrm_sum = ACC_W'(NRM_BASE[r_i]) + ACC_W'(mul_p);

    // Hidden sum in Q.12, its magnitude and the table index split.
    assign hid_sum = $signed(r_acc[HID_SHIFT +: HSUM_W]);
    assign hid_mag = hid_sum[HSUM_W-1] ? HSUM_W'(-hid_sum) : HSUM_W'(hid_sum);
    assign hid_sat = |hid_mag[HSUM_W-1 : TANH_STEP_SH + TANH_IDX_W];

    // Interpolation slope and the interpolated tanh magnitude.
    assign tnh_diff = $signed({1'b0, r_rom_q}) - $signed({1'b0, r_t0});
    assign tnh_val  = $signed(r_acc[TANH_STEP_SH +: ACT_W]);

    // Rounded output in Q.8 with the output offset, before saturation.
    assign rnd_sum  = r_acc + ACC_W'(OUT_ROUND);
    assign est_full = EST_W'($signed(rnd_sum[ACC_W-1:OUT_SHIFT])) + EST_W'(OUT_OFF_Q8[r_o]);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_h         = r_h;
        n_o         = r_o;
        n_samp      = r_samp;
        n_xn        = r_xn;
        n_act       = r_act;
        n_est       = r_est;
        n_acc       = r_acc;
        n_t0        = r_t0;
        n_frac      = r_frac;
        n_neg       = r_neg;
        n_addr      = r_addr;
        n_lo        = r_lo;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mul_a       = '0;
        mul_b       = '0;
        rom_addr    = r_addr;

        // The receiver takes the waiting result word.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_samp[0] = i_data.sample_0;
                    n_samp[1] = i_data.sample_1;
                    n_samp[2] = i_data.sample_2;
                    n_samp[3] = i_data.sample_3;
                    n_samp[4] = i_data.sample_4;
                    n_samp[5] = i_data.sample_5;
                    n_i       = '0;
                    n_state   = S_NRM;
                end
            end

            // One sample per cycle: min-max normalization.
            S_NRM: begin
                mul_a      = MUL_W'(r_samp[r_i]);
                mul_b      = MUL_W'(IN_GAIN_Q16[r_i]);
                n_xn[r_i]  = nrm_sum[NRM_SHIFT +: XN_W];
                if (r_i == LAST_IN) begin
                    n_i     = '0;
                    n_h     = '0;
                    n_state = S_HID_MAC;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            // Hidden neuron: bias plus one weight product per cycle.
            S_HID_MAC: begin
                mul_a = MUL_W'(HID_W_Q16[r_h][r_i]);
                mul_b = MUL_W'(r_xn[r_i]);
                n_acc = ((r_i == '0) ? ACC_W'(HID_INIT[r_h]) : r_acc) + ACC_W'(mul_p);
                if (r_i == LAST_IN) begin
                    n_state = S_TNH_A;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            // Split the sum into table index and fraction; read the lower entry.
            S_TNH_A: begin
                rom_addr = hid_sat ? ROM_LAST
                                   : ROM_AW'(hid_mag[TANH_STEP_SH +: TANH_IDX_W]);
                n_addr   = rom_addr;
                n_frac   = hid_sat ? '0 : hid_mag[TANH_STEP_SH-1:0];
                n_neg    = hid_sum[HSUM_W-1];
                n_state  = S_TNH_B;
            end

            // Lower entry arrives; read the upper one and seed the interpolation.
            S_TNH_B: begin
                rom_addr = (r_addr == ROM_LAST) ? r_addr : r_addr + 1'b1;
                n_t0     = r_rom_q;
                n_acc    = ACC_W'((longint'(r_rom_q) <<< TANH_STEP_SH) + TANH_HALF);
                n_state  = S_TNH_C;
            end

            // Add slope times fraction.
            S_TNH_C: begin
                mul_a   = MUL_W'(tnh_diff);
                mul_b   = MUL_W'(r_frac);
                n_acc   = r_acc + ACC_W'(mul_p);
                n_state = S_TNH_D;
            end

            // Apply the sign and store the activation.
            S_TNH_D: begin
                n_act[r_h] = r_neg ? -tnh_val : tnh_val;
                n_i        = '0;
                if (r_h == LAST_HID) begin
                    n_h     = '0;
                    n_o     = '0;
                    n_state = S_OUT_MAC;
                end else begin
                    n_h     = r_h + 1'b1;
                    n_state = S_HID_MAC;
                end
            end

            // Output neuron: bias plus one activation product per cycle.
            S_OUT_MAC: begin
                mul_a = MUL_W'(OUT_W_Q12[r_o][r_h]);
                mul_b = MUL_W'(r_act[r_h]);
                n_acc = ((r_h == '0) ? ACC_W'(OUT_INIT[r_o]) : r_acc) + ACC_W'(mul_p);
                if (r_h == LAST_HID) begin
                    n_h     = '0;
                    n_state = S_OUT_HI;
                end else begin
                    n_h = r_h + 1'b1;
                end
            end

            // Reciprocal gain, upper half of the sum first.
            S_OUT_HI: begin
                mul_a   = MUL_W'($signed(r_acc[OUT_SPLIT +: OHI_W]));
                mul_b   = MUL_W'(OUT_RGAIN_Q16[r_o]);
                n_lo    = r_acc[OUT_SPLIT-1:0];
                n_acc   = ACC_W'(mul_p);
                n_state = S_OUT_LO;
            end

            // Then the lower half, added to the shifted upper product.
            S_OUT_LO: begin
                mul_a   = MUL_W'(r_lo);
                mul_b   = MUL_W'(OUT_RGAIN_Q16[r_o]);
                n_acc   = (r_acc <<< OUT_SPLIT) + ACC_W'(mul_p);
                n_state = S_OUT_RND;
            end

            // Round, add the offset and saturate to 16 bits.
            S_OUT_RND: begin
                if (est_full > EST_W'(EST_MAX)) begin
                    n_est[r_o] = SAMPLE_W'(EST_MAX);
                end else if (est_full < EST_W'(EST_MIN)) begin
                    n_est[r_o] = SAMPLE_W'(EST_MIN);
                end else begin
                    n_est[r_o] = est_full[SAMPLE_W-1:0];
                end
                if (r_o == LAST_OUT) begin
                    n_state = S_DONE;
                end else begin
                    n_o     = r_o + 1'b1;
                    n_state = S_OUT_MAC;
                end
            end

            // Hand the word to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.estimate_0 = r_est[0];
                    n_out.estimate_1 = r_est[1];
                    n_out.estimate_2 = r_est[2];
                    n_out.estimate_3 = r_est[3];
                    n_out.estimate_4 = r_est[4];
                    n_out.estimate_5 = r_est[5];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters, datapath registers and the table read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_h         <= '0;
            r_o         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_h         <= n_h;
            r_o         <= n_o;
        end
        r_samp  <= n_samp;
        r_xn    <= n_xn;
        r_act   <= n_act;
        r_est   <= n_est;
        r_acc   <= n_acc;
        r_t0    <= n_t0;
        r_frac  <= n_frac;
        r_neg   <= n_neg;
        r_addr  <= n_addr;
        r_lo    <= n_lo;
        r_out   <= n_out;
        r_rom_q <= TANH_ROM[rom_addr];
    end

    // A taken word always starts the normalization pass.
    `MLPC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && !o_stall, r_state == S_NRM, "accepted word did not start normalization")

    // A finished result never overwrites one that still waits.
    `MLPC_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && i_stall, r_state == S_DONE, "result left while output register was full")

    // The result register only fills from the final step.
    `MLPC_ASSERT_NOW(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE), "output valid rose outside the final step")

    // Interpolated tanh never exceeds one.
    `MLPC_ASSERT_NOW(a_tanh_bound, i_clk, i_rst_n, r_state == S_TNH_D, (tnh_val >= 0) && (tnh_val <= ACT_W'(TANH_ONE)), "tanh magnitude out of range")

    // Output layer indexes stay inside the weight table.
    `MLPC_ASSERT_NOW(a_out_index, i_clk, i_rst_n, r_state == S_OUT_MAC, (r_o <= LAST_OUT) && (r_h <= LAST_HID), "output layer index out of range")

endmodule

@@ test/tb_mlp_compensation_6_10_6.sv @@
module tb_mlp_compensation_6_10_6;
    import mlpc_pkg::t_in_word;
    import mlpc_pkg::t_out_word;

    localparam int N_IN  = 6;
    localparam int N_HID = 10;
    localparam int N_OUT = 6;
    localparam int FIELD_W = 16;

    // Tanh table geometry, Q.12 input span of four.
    localparam int TBL_DEPTH = 256;
    localparam int TBL_STEP  = 16384 / TBL_DEPTH;
    localparam longint unsigned TBL_Q31_ONE = 64'h8000_0000;

    localparam longint ONE_Q24  = 64'sd16777216;
    localparam longint OUT_HALF = 64'sh8000_0000;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 1200;
    localparam int PHASE_WORDS   = 305;
    localparam int BURST_WORDS   = 12;
    localparam int REPORT_MAX    = 10;

    // Network constants.
    localparam longint NRM_OFF_Q8   [N_IN] = '{8669, 7951, 8257, 7693, 8362, 8659};
    localparam longint NRM_GAIN_Q16 [N_IN] = '{4161, 3742, 3917, 3614, 4020, 4043};
    localparam longint HID_BIAS [N_HID] = '{
        57099, 49275, 44446, -43748, 47855, -50548, 47771, -48258, 47267, 47991};
    localparam longint HID_WGT [N_HID][N_IN] = '{
        '{-34111, 10521, -6875, -8262, 6315, 11937},
        '{-145, 3568, -1674, -17789, 10470, -7343},
        '{-639, -7392, 2484, -2464, -10825, 5917},
        '{-651, 6906, 965, -368, 5535, -521},
        '{7939, -8844, 3533, 1282, -6010, -14874},
        '{-1871, -5329, 5670, 10330, -4560, 7055},
        '{14125, 3727, -8966, -1305, 4609, -32696},
        '{-4177, -6978, 9637, 3663, -841, 12806},
        '{2905, -5849, 2418, 851, -13502, -3484},
        '{2911, -9938, -3596, 3721, -4118, -1063}};
    localparam longint OUT_BIAS [N_OUT] = '{21242, -18171, 37180, 46295, 125055, -6618};
    localparam longint OUT_WGT [N_OUT][N_HID] = '{
        '{3898, 49937, -84989, -176502, -17055, 148011, 5057, -82895, -18669, -74081},
        '{-8376, -42975, -23904, 66495, -34291, -83307, 15412, 50518, 28056, 122427},
        '{5906, 64927, 187409, 493941, 34573, 155795, -17938, -110697, -28113, 215494},
        '{-2652, 134378, 604066, 766763, 467918, 690907, -237824, -814931, -508292,
          111586},
        '{-25930, 464625, -105378, -294766, -92039, 1048611, -51902, -460351, 54496,
          -105765},
        '{-17223, 101401, 217857, 245292, 208362, 139008, -45808, -102053, -234102,
          61485}};
    localparam longint OUT_RGAIN [N_OUT] = '{655275, 655216, 882332, 524235, 524227, 524167};
    localparam longint OUT_OFF_Q8 [N_OUT] = '{-2559, -2560, 8979, -2048, -2048, -2048};

    // Sample values for the directed words.
    localparam logic [15:0] S_MAX = 16'h7FFF;
    localparam logic [15:0] S_MIN = 16'h8000;
    localparam logic [15:0] C0 = 16'd12701;
    localparam logic [15:0] C1 = 16'd12435;
    localparam logic [15:0] C2 = 16'd12540;
    localparam logic [15:0] C3 = 16'd12335;
    localparam logic [15:0] C4 = 16'd12535;
    localparam logic [15:0] C5 = 16'd12809;

    localparam int N_DIRECTED = 24;
    localparam t_in_word DIRECTED_ROWS [N_DIRECTED] = '{
        {6{16'h0000}},
        {6{S_MAX}},
        {6{S_MIN}},
        {S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
        {S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX},
        {6{16'h5555}},
        {6{16'hAAAA}},
        // Middle of the training range on every input.
        {C0, C1, C2, C3, C4, C5},
        // Lower and upper edge of the training range.
        {16'd8669, 16'd7951, 16'd8257, 16'd7693, 16'd8362, 16'd8659},
        {16'd16733, 16'd16918, 16'd16823, 16'd16978, 16'd16709, 16'd16958},
        // One input far out of range at a time.
        {S_MAX, C1, C2, C3, C4, C5},
        {C0, S_MAX, C2, C3, C4, C5},
        {C0, C1, S_MAX, C3, C4, C5},
        {C0, C1, C2, S_MAX, C4, C5},
        {C0, C1, C2, C3, S_MAX, C5},
        {C0, C1, C2, C3, C4, S_MAX},
        {S_MIN, C1, C2, C3, C4, C5},
        {C0, S_MIN, C2, C3, C4, C5},
        {C0, C1, S_MIN, C3, C4, C5},
        {C0, C1, C2, S_MIN, C4, C5},
        {C0, C1, C2, C3, S_MIN, C5},
        {C0, C1, C2, C3, C4, S_MIN},
        // Drives the seventh hidden neuron past the end of the tanh table.
        {S_MIN, C1, C2, C3, C4, S_MAX},
        {16'h0001, 16'hFFFF, 16'h0100, 16'hFF00, 16'h7F00, 16'h8100}};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;

    longint    tanh_q12 [TBL_DEPTH + 1];
    t_out_word expected_estimates [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    logic      hold_req = 1'b0;
    logic      hold_ack = 1'b0;
    int        hold_left = 0;

    mlp_compensation_6_10_6 DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    always #10 clk = ~clk;

    // Tanh table in Q.12: exp(-2x) from a Taylor series in Q.31, squared four times.
    initial begin : build_tanh_table
        longint unsigned r;
        longint unsigned term;
        longint unsigned e;
        longint          acc;
        for (int k = 0; k <= TBL_DEPTH; k++) begin
            r = longint'(2 * k * TBL_STEP) << 15;
            if (r > (TBL_Q31_ONE >> 1)) begin
                r = TBL_Q31_ONE >> 1;
            end
            term = TBL_Q31_ONE;
            acc  = longint'(TBL_Q31_ONE);
            for (int t = 1; t <= 16; t++) begin
                term = ((term * r) >> 31) / longint'(t);
                if (t % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(TBL_Q31_ONE)) begin
                acc = longint'(TBL_Q31_ONE);
            end
            e = acc;
            repeat (4) begin
                e = (e * e + (TBL_Q31_ONE >> 1)) >> 31;
            end
            tanh_q12[k] = longint'((2 * (TBL_Q31_ONE - e) * 4096 + (TBL_Q31_ONE + e))
                                   / (2 * (TBL_Q31_ONE + e)));
        end
    end

    // Computes the six estimates for one sample word.
    function automatic t_out_word compensate_samples(input t_in_word w);
        logic signed [15:0] smp;
        longint    xn [N_IN];
        longint    act [N_HID];
        longint    acc;
        longint    hsum;
        longint    mag;
        longint    idx;
        longint    frac;
        longint    v;
        t_out_word res;
        for (int c = 0; c < N_IN; c++) begin
            smp = w[(N_IN - 1 - c) * FIELD_W +: FIELD_W];
            xn[c] = (((longint'(smp) - NRM_OFF_Q8[c]) * NRM_GAIN_Q16[c] + 2048) >>> 12)
                    - 4096;
        end
        // Hidden layer with interpolated tanh, mirrored for negative sums.
        for (int h = 0; h < N_HID; h++) begin
            acc = HID_BIAS[h] * 4096;
            for (int c = 0; c < N_IN; c++) begin
                acc += HID_WGT[h][c] * xn[c];
            end
            hsum = (acc + 32768) >>> 16;
            mag  = (hsum < 0) ? -hsum : hsum;
            idx  = mag / TBL_STEP;
            if (idx >= TBL_DEPTH) begin
                v = tanh_q12[TBL_DEPTH];
            end else begin
                frac = mag - idx * TBL_STEP;
                v = tanh_q12[int'(idx)]
                    + (((tanh_q12[int'(idx) + 1] - tanh_q12[int'(idx)]) * frac
                        + TBL_STEP / 2) >>> $clog2(TBL_STEP));
            end
            act[h] = (hsum < 0) ? -v : v;
        end
        // Output layer, reverse scaling and saturation.
        for (int o = 0; o < N_OUT; o++) begin
            acc = OUT_BIAS[o] * 4096 + ONE_Q24;
            for (int h = 0; h < N_HID; h++) begin
                acc += OUT_WGT[o][h] * act[h];
            end
            v = ((acc * OUT_RGAIN[o] + OUT_HALF) >>> 32) + OUT_OFF_Q8[o];
            if (v > 32767) begin
                v = 32767;
            end
            if (v < -32768) begin
                v = -32768;
            end
            res[(N_OUT - 1 - o) * FIELD_W +: FIELD_W] = v[15:0];
        end
        return res;
    endfunction

    // Random sample word: mostly in and near the training range, some full range,
    // some mixed with the field extremes.
    function automatic t_in_word draw_samples();
        t_in_word    w;
        logic [15:0] s;
        int          kind;
        kind = $urandom_range(99);
        for (int c = 0; c < N_IN; c++) begin
            if (kind < 60) begin
                s = 16'(NRM_OFF_Q8[c] - 1024 + longint'($urandom_range(10400)));
            end else if (kind < 85) begin
                s = 16'($urandom);
            end else begin
                case ($urandom_range(3))
                    0: begin
                        s = S_MAX;
                    end
                    1: begin
                        s = S_MIN;
                    end
                    2: begin
                        s = 16'($urandom);
                    end
                    default: begin
                        s = 16'(NRM_OFF_Q8[c] + longint'($urandom_range(8192)));
                    end
                endcase
            end
            w[(N_IN - 1 - c) * FIELD_W +: FIELD_W] = s;
        end
        return w;
    endfunction

    // Offers one word, with random idle cycles first, and returns once it is taken.
    task automatic offer_word(input t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Receiver stall: a long hold when requested, random stalls otherwise.
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Compares each taken result word with the oldest expected word, and
    // queues the expected word for each sample word taken.
    always @(posedge clk) begin : score
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_estimates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result word %h", out_data);
                end
            end else begin
                want = expected_estimates.pop_front();
                for (int o = 0; o < N_OUT; o++) begin
                    if (out_data[(N_OUT - 1 - o) * FIELD_W +: FIELD_W]
                        !== want[(N_OUT - 1 - o) * FIELD_W +: FIELD_W]) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("estimate_%0d: expected %0d, got %0d", o,
                                     $signed(want[(N_OUT - 1 - o) * FIELD_W +: FIELD_W]),
                                     $signed(out_data[(N_OUT - 1 - o) * FIELD_W +: FIELD_W]));
                        end
                    end
                end
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            expected_estimates.push_back(compensate_samples(in_data));
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_mlp_compensation_6_10_6: errors");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (5) begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // Directed words, no idling on either side.
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_word(DIRECTED_ROWS[i]);
        end

        // Receiver holds off while words keep coming, so the block backs up.
        hold_req <= ~hold_req;
        repeat (BURST_WORDS) begin
            offer_word(draw_samples());
        end

        // Random words under four idling patterns.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct  <= 88;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 88;
                end
                default: begin
                    tx_idle_pct  <= 26;
                    rx_stall_pct <= 26;
                end
            endcase
            repeat (PHASE_WORDS) begin
                offer_word(draw_samples());
            end
        end
        in_valid <= 1'b0;

        // Drain the remaining results, then let the block settle.
        @(posedge clk);
        while (expected_estimates.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && expected_estimates.size() == 0) begin
            $display("tb_mlp_compensation_6_10_6: clean");
        end else begin
            $display("tb_mlp_compensation_6_10_6: errors");
        end
        $finish;
    end

endmodule

@@ mlp_compensation_6_10_6.f @@
+incdir+rtl/core
rtl/core/mlpc_pkg.sv
rtl/core/mlp_compensation_6_10_6.sv
test/tb_mlp_compensation_6_10_6.sv
